// ===== rtl/kmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared constants, op codes and sequencer states of the 2-D k-means unit.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int NUM_CENTROIDS = 5;
  localparam int MAX_POINTS    = 1024;
  localparam int COORD_W       = 16;
  localparam int PIDX_W        = $clog2(MAX_POINTS);
  localparam int PCNT_W        = PIDX_W + 1;
  localparam int KIDX_W        = 3;
  localparam int SUM_W         = COORD_W + PIDX_W + 1;
  localparam int MAG_W         = SUM_W - 1;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int DIST_W        = SQ_W + 1;
  localparam int ITER_W        = 16;
  localparam int DCNT_W        = $clog2(MAG_W);

  localparam logic [1:0] OP_POINT    = 2'd0;
  localparam logic [1:0] OP_CENTROID = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_QUERY    = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_QRY  = 9'b000000010,
    S_RD   = 9'b000000100,
    S_SQX  = 9'b000001000,
    S_SQY  = 9'b000010000,
    S_WB   = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

endpackage

// ===== rtl/kmeans_clustering_2d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_clustering_2d_unit
// Lloyd k-means over up to 1024 signed Q1.15 points and five centroids.
// ----------------------------------------------------------------------------
// Load items (points, initial centroids) are stored while the unit is idle.
// A point marked last starts a run: each assignment pass reads every point
// and, for each centroid, squares dx and dy in turn on one shared 17x17
// squarer before the nearest centroid is written back. Each centroid update
// between passes runs up to 10 divisions in a shared bit-serial divider.
// After the last pass, five centroid records are sent. A query looks up the
// stored assignment of its target point, then sends one result record. Input
// is not accepted while a run, a query or result output is in progress.
module kmeans_clustering_2d_unit
  import kmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,      // max_iterations
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], coord_x[17:2], coord_y[33:18], target_index[43:34], zero fill
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cluster_index[2:0], center_x[18:3], center_y[34:19], member_count[45:35],
  // iterations_used[61:46], converged[62], zero fill
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_result
);

  state_t state;

  logic [ITER_W-1:0] max_iter;
  logic [ITER_W-1:0] pass_cnt;
  logic              changed;
  logic              first;
  logic              run_ended;
  logic [PCNT_W-1:0] point_total;
  logic [PCNT_W-1:0] assigned_total;

  logic signed [COORD_W-1:0] cx [NUM_CENTROIDS];
  logic signed [COORD_W-1:0] cy [NUM_CENTROIDS];
  logic signed [SUM_W-1:0]   sum_x [NUM_CENTROIDS];
  logic signed [SUM_W-1:0]   sum_y [NUM_CENTROIDS];
  logic [PCNT_W-1:0]         cnt [NUM_CENTROIDS];

  logic [2*COORD_W-1:0] pmem [MAX_POINTS];
  logic [KIDX_W-1:0]    amem [MAX_POINTS];
  logic [2*COORD_W-1:0] prd;
  logic [KIDX_W-1:0]    ard;

  logic [PIDX_W-1:0] pi;
  logic [KIDX_W-1:0] kk;
  logic [KIDX_W-1:0] bk;
  logic [KIDX_W-1:0] ok;
  logic [KIDX_W-1:0] dk;
  logic              ddim;
  logic [DIST_W-1:0] best;
  logic [SQ_W-1:0]   sq;

  logic              dbusy;
  logic              dneg;
  logic [DCNT_W-1:0] dcnt;
  logic [MAG_W-1:0]  dq;
  logic [PCNT_W-1:0] drem;

  logic              qmode;
  logic              qvalid;
  logic [PIDX_W-1:0] qidx;

  // Input fields
  logic [1:0]                op_in;
  logic signed [COORD_W-1:0] x_in;
  logic signed [COORD_W-1:0] y_in;
  logic [PIDX_W-1:0]         idx_in;
  assign op_in  = s_axis_tdata[1:0];
  assign x_in   = s_axis_tdata[17:2];
  assign y_in   = s_axis_tdata[33:18];
  assign idx_in = s_axis_tdata[43:34];

  logic in_xfer, out_xfer;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // Shared centroid-bank index
  logic [KIDX_W-1:0] kidx;
  always_comb begin
    case (state)
      S_OUT:   kidx = ok;
      S_DIV:   kidx = dk;
      S_WB:    kidx = bk;
      default: kidx = kk;
    endcase
  end

  logic signed [COORD_W-1:0] cx_k, cy_k, px, py;
  logic signed [SUM_W-1:0]   sum_k;
  logic [PCNT_W-1:0]         cnt_k;
  assign cx_k  = cx[kidx];
  assign cy_k  = cy[kidx];
  assign cnt_k = cnt[kidx];
  assign sum_k = ddim ? sum_y[kidx] : sum_x[kidx];
  assign px    = prd[COORD_W-1:0];
  assign py    = prd[2*COORD_W-1:COORD_W];

  // Shared squarer
  logic signed [DIFF_W-1:0] diff;
  logic signed [SQ_W-1:0]   prod;
  logic [DIST_W-1:0]        dcand;
  assign diff = (state == S_SQX) ? (DIFF_W'(px) - DIFF_W'(cx_k))
                                 : (DIFF_W'(py) - DIFF_W'(cy_k));
  assign prod = diff * diff;
  assign dcand = DIST_W'(sq) + DIST_W'(unsigned'(prod));

  // Divider step
  logic [PCNT_W:0]  dtrial;
  logic             dbit;
  logic [MAG_W-1:0] dq_next;
  logic [MAG_W-1:0] dres;
  assign dtrial  = {drem, dq[MAG_W-1]};
  assign dbit    = (dtrial >= {1'b0, cnt_k});
  assign dq_next = {dq[MAG_W-2:0], dbit};
  assign dres    = dneg ? (MAG_W'(0) - dq_next) : dq_next;

  // Point load bookkeeping
  logic [PCNT_W-1:0] eff_total;
  logic              pwe;
  assign eff_total = run_ended ? '0 : point_total;
  assign pwe = in_xfer && (op_in == OP_POINT) && (eff_total < PCNT_W'(MAX_POINTS));

  logic [PIDX_W-1:0] ard_addr;
  assign ard_addr = (state == S_IDLE) ? idx_in : pi;

  always_ff @(posedge clk) begin
    if (pwe) pmem[eff_total[PIDX_W-1:0]] <= {y_in, x_in};
    prd <= pmem[pi];
    if (state == S_WB) amem[pi] <= bk;
    ard <= amem[ard_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      max_iter       <= ITER_W'(100);
      pass_cnt       <= '0;
      changed        <= 1'b0;
      first          <= 1'b0;
      run_ended      <= 1'b0;
      point_total    <= '0;
      assigned_total <= '0;
      dbusy          <= 1'b0;
      qmode          <= 1'b0;
      qvalid         <= 1'b0;
      for (int k = 0; k < NUM_CENTROIDS; k++) begin
        cx[k]    <= '0;
        cy[k]    <= '0;
        sum_x[k] <= '0;
        sum_y[k] <= '0;
        cnt[k]   <= '0;
      end
    end else begin
      if (cfg_valid) max_iter <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (op_in)
              OP_POINT: begin
                run_ended   <= 1'b0;
                point_total <= pwe ? eff_total + 1'b1 : eff_total;
                if (s_axis_tlast) begin
                  pi      <= '0;
                  kk      <= '0;
                  first   <= 1'b1;
                  changed <= 1'b1;
                  pass_cnt <= '0;
                  for (int k = 0; k < NUM_CENTROIDS; k++) begin
                    sum_x[k] <= '0;
                    sum_y[k] <= '0;
                    cnt[k]   <= '0;
                  end
                  state <= S_RD;
                end
              end
              OP_CENTROID: begin
                if (idx_in < PIDX_W'(NUM_CENTROIDS)) begin
                  cx[idx_in[KIDX_W-1:0]] <= x_in;
                  cy[idx_in[KIDX_W-1:0]] <= y_in;
                end
              end
              OP_QUERY: begin
                qidx  <= idx_in;
                state <= S_QRY;
              end
              default: ;
            endcase
          end
        end
        S_QRY: begin
          qmode  <= 1'b1;
          qvalid <= ({1'b0, qidx} < assigned_total);
          ok     <= (ard >= KIDX_W'(NUM_CENTROIDS)) ? ard - KIDX_W'(NUM_CENTROIDS) : ard;
          state  <= S_OUT;
        end
        S_RD: state <= S_SQX;
        S_SQX: begin
          sq    <= unsigned'(prod);
          state <= S_SQY;
        end
        S_SQY: begin
          if (kk == '0 || dcand < best) begin
            best <= dcand;
            bk   <= kk;
          end
          if (kk == KIDX_W'(NUM_CENTROIDS - 1)) begin
            state <= S_WB;
          end else begin
            kk    <= kk + 1'b1;
            state <= S_SQX;
          end
        end
        S_WB: begin
          sum_x[bk] <= sum_x[bk] + SUM_W'(px);
          sum_y[bk] <= sum_y[bk] + SUM_W'(py);
          cnt[bk]   <= cnt_k + 1'b1;
          if (!first && bk != ard) changed <= 1'b1;
          kk <= '0;
          pi <= pi + 1'b1;
          if (PCNT_W'(pi) + 1'b1 == point_total) state <= S_CHK;
          else                                   state <= S_RD;
        end
        S_CHK: begin
          if (!changed || pass_cnt >= max_iter) begin
            assigned_total <= point_total;
            run_ended      <= 1'b1;
            qmode          <= 1'b0;
            ok             <= '0;
            state          <= S_OUT;
          end else begin
            dk    <= '0;
            ddim  <= 1'b0;
            dbusy <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!dbusy && cnt_k != '0) begin
            // Load magnitude, run restoring division
            dneg  <= sum_k[SUM_W-1];
            dq    <= sum_k[SUM_W-1] ? MAG_W'(-sum_k) : MAG_W'(sum_k);
            drem  <= '0;
            dcnt  <= '0;
            dbusy <= 1'b1;
          end else begin
            if (dbusy) begin
              drem <= dbit ? PCNT_W'(dtrial - {1'b0, cnt_k}) : PCNT_W'(dtrial);
              dq   <= dq_next;
              dcnt <= dcnt + 1'b1;
            end
            if (!dbusy || dcnt == DCNT_W'(MAG_W - 1)) begin
              dbusy <= 1'b0;
              if (dbusy) begin
                if (ddim) cy[dk] <= dres[COORD_W-1:0];
                else      cx[dk] <= dres[COORD_W-1:0];
              end
              if (ddim) begin
                ddim <= 1'b0;
                if (dk == KIDX_W'(NUM_CENTROIDS - 1)) begin
                  pass_cnt <= pass_cnt + 1'b1;
                  changed  <= 1'b0;
                  first    <= 1'b0;
                  pi       <= '0;
                  kk       <= '0;
                  for (int k = 0; k < NUM_CENTROIDS; k++) begin
                    sum_x[k] <= '0;
                    sum_y[k] <= '0;
                    cnt[k]   <= '0;
                  end
                  state <= S_RD;
                end else begin
                  dk <= dk + 1'b1;
                end
              end else begin
                ddim <= 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (qmode || ok == KIDX_W'(NUM_CENTROIDS - 1)) state <= S_IDLE;
            else                                           ok    <= ok + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields
  logic show;
  assign show          = !qmode || qvalid;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tuser  = qmode ? KIND_QUERY : KIND_CENTROID;
  assign m_axis_tlast  = qmode || (ok == KIDX_W'(NUM_CENTROIDS - 1));
  assign m_axis_tdata  = show ? {1'b0, !changed, pass_cnt, cnt_k, cy_k, cx_k, ok} : '0;

  // Checks
  a_ready_vs_result: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    dbusy |-> (state == S_DIV))
    else $error("divider busy outside the update step");
  a_point_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQX) |-> (PCNT_W'(pi) < point_total))
    else $error("point index beyond stored points");

endmodule
